@@ hw/rtl/dxfgc_pkg.sv @@
package dxfgc_pkg;

	// field widths fixed by the stream format
	localparam int VALUE_LIMIT_W = 10;
	localparam int CODE_W        = 32;
	localparam int LIMIT_RESET   = 512;

	// characters the code line parser looks at
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	// group code that marks a comment pair
	localparam logic [CODE_W-1:0] COMMENT_CODE = 32'd999;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_EOV  = 2'd1,
		KIND_EOD  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_BLANK = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		BRK_NONE = 2'd0,
		BRK_CR   = 2'd1,
		BRK_LF   = 2'd2
	} brk_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_beat_t;

	typedef struct packed {
		logic signed [CODE_W-1:0] group_code;
		logic [7:0]               value_char;
		kind_t                    kind;
		logic                     truncated;
	} out_beat_t;

endpackage

@@ hw/rtl/dxfgc_in_stage.sv @@
module dxfgc_in_stage
	import dxfgc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_beat_t in_data,
	input  logic     adv,
	output logic     valid_s1,
	output in_beat_t data_s1
);

	logic free;

	// stage is free when empty or when its beat moves on this cycle
	assign free     = !valid_s1 || adv;
	assign in_stall = !free;

	// valid bit of the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (free) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input register
	always_ff @(posedge clk) begin
		if (free && in_valid) begin
			data_s1 <= in_data;
		end
	end

endmodule

@@ hw/rtl/dxfgc_core.sv @@
module dxfgc_core
	import dxfgc_pkg::*;
#(
	parameter int MAX_VALUE_BUFFER = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     value_limit_we,
	input  logic [VALUE_LIMIT_W-1:0] value_limit,
	input  logic                     valid_s1,
	input  in_beat_t                 data_s1,
	output logic                     adv,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_beat_t                out_data
);

	localparam int KW = (MAX_VALUE_BUFFER > 2) ? $clog2(MAX_VALUE_BUFFER) : 1;
	localparam int CW = $clog2(MAX_VALUE_BUFFER + 1);
	localparam int LW = (CW > VALUE_LIMIT_W) ? CW : VALUE_LIMIT_W;
	localparam int RESET_LIM = (LIMIT_RESET > MAX_VALUE_BUFFER) ? MAX_VALUE_BUFFER
		: LIMIT_RESET;

	// parse state
	logic              in_value_q, n_in_value;
	brk_t              pend_q, n_pend;
	logic [CODE_W-1:0] acc_q, n_acc;
	logic              neg_q, n_neg;
	phase_t            phase_q, n_phase;
	logic              comment_q, n_comment;
	logic [KW-1:0]     kept_q, n_kept;
	logic              dropped_q, n_dropped;
	logic [KW-1:0]     keep_max_q, keep_max_d;

	// step signals
	logic [7:0]        b;
	logic              is_end, swallow, is_break, is_digit, is_blank, is_sign;
	logic [3:0]        dval;
	logic [CODE_W-1:0] acc_x10, code_fin;
	logic              res_v;
	out_beat_t         res;
	logic              load_s2;
	logic              valid_s2;
	out_beat_t         data_s2;
	logic [LW-1:0]     lim_w;

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// output register is free when empty or taken this cycle
	assign load_s2 = !(valid_s2 && out_stall);
	assign adv     = valid_s1 && load_s2;

	// clamp the configured buffer size to the kept-character ceiling
	always_comb begin
		lim_w = LW'(value_limit);
		if (lim_w > LW'(MAX_VALUE_BUFFER)) begin
			keep_max_d = KW'(MAX_VALUE_BUFFER - 1);
		end else if (lim_w == '0) begin
			keep_max_d = '0;
		end else begin
			keep_max_d = KW'(lim_w - LW'(1));
		end
	end

	// byte classes
	assign b        = data_s1.data_byte;
	assign is_end   = data_s1.end_of_data || (b == CH_NUL);
	assign swallow  = ((pend_q == BRK_CR) && (b == CH_LF)) || ((pend_q == BRK_LF) && (b == CH_CR));
	assign is_break = (b == CH_CR) || (b == CH_LF);
	assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
	assign is_blank = (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
	assign is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
	assign dval     = 4'(b - CH_ZERO);

	// atoi step: acc * 10 + digit, wrapping at 32 bits
	assign acc_x10 = {acc_q[CODE_W-4:0], 3'b000} + {acc_q[CODE_W-2:0], 1'b0}
		+ CODE_W'(dval);
	assign code_fin = neg_q ? (CODE_W'(0) - acc_q) : acc_q;

	// next state and result for the beat in the input register
	always_comb begin
		n_in_value = in_value_q;
		n_pend     = pend_q;
		n_acc      = acc_q;
		n_neg      = neg_q;
		n_phase    = phase_q;
		n_comment  = comment_q;
		n_kept     = kept_q;
		n_dropped  = dropped_q;
		res_v      = 1'b0;
		res        = '{group_code: '0, value_char: '0, kind: KIND_EOD, truncated: 1'b0};

		if (is_end) begin
			n_in_value = 1'b0;
			n_pend     = BRK_NONE;
			n_acc      = '0;
			n_neg      = 1'b0;
			n_phase    = PH_BLANK;
			n_comment  = 1'b0;
			n_kept     = '0;
			n_dropped  = 1'b0;
			res_v      = 1'b1;
		end else begin
			n_pend = BRK_NONE;
			if (!swallow) begin
				if (is_break) begin
					n_pend = (b == CH_CR) ? BRK_CR : BRK_LF;
					if (!in_value_q) begin
						// code line done: fix sign, enter value line
						n_acc      = code_fin;
						n_neg      = 1'b0;
						n_phase    = PH_BLANK;
						n_comment  = (code_fin == COMMENT_CODE);
						n_in_value = 1'b1;
						n_kept     = '0;
						n_dropped  = 1'b0;
					end else begin
						// value line done: end of value unless comment
						n_in_value = 1'b0;
						n_acc      = '0;
						n_neg      = 1'b0;
						n_phase    = PH_BLANK;
						n_comment  = 1'b0;
						n_kept     = '0;
						n_dropped  = 1'b0;
						if (!comment_q) begin
							res_v          = 1'b1;
							res.group_code = acc_q;
							res.kind       = KIND_EOV;
							res.truncated  = dropped_q;
						end
					end
				end else if (!in_value_q) begin
					unique case (phase_q)
						PH_BLANK: begin
							if (is_blank) begin
								n_phase = PH_BLANK;
							end else if (is_sign) begin
								n_neg   = (b == CH_MINUS);
								n_phase = PH_SIGN;
							end else if (is_digit) begin
								n_acc   = CODE_W'(dval);
								n_phase = PH_DIGIT;
							end else begin
								n_phase = PH_DONE;
							end
						end
						PH_SIGN, PH_DIGIT: begin
							if (is_digit) begin
								n_acc   = acc_x10;
								n_phase = PH_DIGIT;
							end else begin
								n_phase = PH_DONE;
							end
						end
						PH_DONE: begin
							n_phase = PH_DONE;
						end
					endcase
				end else if (!comment_q) begin
					if (kept_q < keep_max_q) begin
						n_kept         = kept_q + KW'(1);
						res_v          = 1'b1;
						res.group_code = acc_q;
						res.value_char = b;
						res.kind       = KIND_CHAR;
					end else begin
						n_dropped = 1'b1;
					end
				end
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_max_q <= KW'(RESET_LIM - 1);
		end else if (value_limit_we) begin
			keep_max_q <= keep_max_d;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_value_q <= 1'b0;
			pend_q     <= BRK_NONE;
			acc_q      <= '0;
			neg_q      <= 1'b0;
			phase_q    <= PH_BLANK;
			comment_q  <= 1'b0;
			kept_q     <= '0;
			dropped_q  <= 1'b0;
		end else if (adv) begin
			in_value_q <= n_in_value;
			pend_q     <= n_pend;
			acc_q      <= n_acc;
			neg_q      <= n_neg;
			phase_q    <= n_phase;
			comment_q  <= n_comment;
			kept_q     <= n_kept;
			dropped_q  <= n_dropped;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1 && res_v;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			data_s2 <= res;
		end
	end

`ifndef ASSERT_OFF
	// comment flag only lives inside a value line
	a_comment_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		comment_q |-> in_value_q)
		else $error("comment flag set outside value line");

	// code parsing state is idle during a value line
	a_phase_idle_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		in_value_q |-> (phase_q == PH_BLANK) && !neg_q)
		else $error("code parser active inside value line");

	// kept characters only counted inside a value line
	a_kept_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		(kept_q != '0) |-> in_value_q)
		else $error("kept count nonzero on code line");

	// end of data clears the pair state and produces a result beat
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_end) |=> !in_value_q && (acc_q == '0) && valid_s2
			&& (data_s2.kind == KIND_EOD))
		else $error("end of data did not reset parser");
`endif

endmodule

@@ hw/rtl/dxf_group_code_pair_tokenizer.sv @@
// DXF group code / value pair tokenizer.
// Input channel in_valid/in_stall/in_data carries one byte of the text stream per beat,
// or an end-of-data mark. Output channel out_valid/out_stall/out_data carries one result
// per beat: a kept value character with its group code, an end of value (with the
// truncation flag), or an end of data. Comment pairs (code 999) give no results.
// value_limit_we/value_limit set the value buffer size; at most size minus one characters
// of a value are kept. Write it only while no bytes are in flight.
// A byte accepted sits in the input register, is parsed from there, and its result is
// loaded into the result register that drives out_valid and out_data.
// Throughput: one byte per cycle while out_stall does not hold the parser; the parse state
// (including the times-ten-plus-digit code accumulator) is updated from the input register.
// When out_stall is high with a result waiting, the result register holds, the parser
// stops and in_stall rises once the input register is full; bytes that give no result
// still pass while the output side is free.
// Reset (arst_n low) empties both registers, clears the parse state to the start of a
// code line and sets the buffer size to 512 (clamped to MAX_VALUE_BUFFER).
module dxf_group_code_pair_tokenizer
	import dxfgc_pkg::*;
#(
	parameter int MAX_VALUE_BUFFER = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     value_limit_we,
	input  logic [VALUE_LIMIT_W-1:0] value_limit,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_beat_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_beat_t                out_data
);

	logic     valid_s1;
	in_beat_t data_s1;
	logic     adv;

	// input register
	dxfgc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	// parser and result register
	dxfgc_core #(
		.MAX_VALUE_BUFFER (MAX_VALUE_BUFFER)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.value_limit_we (value_limit_we),
		.value_limit    (value_limit),
		.valid_s1       (valid_s1),
		.data_s1        (data_s1),
		.adv            (adv),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data)
	);

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	import dxfgc_pkg::*;

	localparam int VALUE_BUF_MAX = 512;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_BYTES   = 20;
	localparam int LONG_VALUE    = 515;

	// one byte to send, optionally with its result written out by hand
	typedef struct packed {
		in_beat_t  beat;
		logic      typed;
		out_beat_t want;
	} feed_t;

	// hand-written opening sequence; untyped rows go through the tokenizer model
	localparam feed_t OPENING [24] = '{
		'{'{8'hFF, 1'b1}, 1'b1, '{32'sd0, 8'h00, KIND_EOD, 1'b0}},
		'{'{CH_NUL, 1'b0}, 1'b1, '{32'sd0, 8'h00, KIND_EOD, 1'b0}},
		'{'{CH_SP, 1'b0}, 1'b0, '0},
		'{'{CH_MINUS, 1'b0}, 1'b0, '0},
		'{'{8'h31, 1'b0}, 1'b0, '0},
		'{'{8'h32, 1'b0}, 1'b0, '0},
		'{'{8'h78, 1'b0}, 1'b0, '0},
		'{'{CH_CR, 1'b0}, 1'b0, '0},
		'{'{CH_LF, 1'b0}, 1'b0, '0},
		'{'{8'h41, 1'b0}, 1'b1, '{-32'sd12, 8'h41, KIND_CHAR, 1'b0}},
		'{'{CH_LF, 1'b0}, 1'b1, '{-32'sd12, 8'h00, KIND_EOV, 1'b0}},
		'{'{CH_CR, 1'b0}, 1'b0, '0},
		'{'{CH_NINE, 1'b0}, 1'b0, '0},
		'{'{CH_NINE, 1'b0}, 1'b0, '0},
		'{'{CH_NINE, 1'b0}, 1'b0, '0},
		'{'{CH_LF, 1'b0}, 1'b0, '0},
		'{'{8'h7A, 1'b0}, 1'b0, '0},
		'{'{CH_LF, 1'b0}, 1'b0, '0},
		'{'{CH_LF, 1'b0}, 1'b0, '0},
		'{'{8'hFF, 1'b0}, 1'b1, '{32'sd0, 8'hFF, KIND_CHAR, 1'b0}},
		'{'{CH_CR, 1'b0}, 1'b1, '{32'sd0, 8'h00, KIND_EOV, 1'b0}},
		'{'{CH_CR, 1'b0}, 1'b0, '0},
		'{'{8'h76, 1'b0}, 1'b0, '0},
		'{'{8'h5A, 1'b1}, 1'b1, '{32'sd0, 8'h00, KIND_EOD, 1'b0}}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     value_limit_we = 1'b0;
	logic [VALUE_LIMIT_W-1:0] value_limit = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	in_beat_t                 in_data = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	out_beat_t                out_data;

	// tokenizer model state
	logic                     tk_in_value;
	brk_t                     tk_brk;
	logic [CODE_W-1:0]        tk_code;
	logic                     tk_neg;
	phase_t                   tk_phase;
	logic                     tk_comment;
	int unsigned              tk_kept;
	logic                     tk_dropped;
	logic [VALUE_LIMIT_W-1:0] limit_setting = VALUE_LIMIT_W'(LIMIT_RESET);

	feed_t       byte_feed [$];
	out_beat_t   pending_results [$];
	feed_t       cur_feed;
	int unsigned fed_total = 0;
	int unsigned errors = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	int unsigned stall_mode = 0;
	int unsigned quiet_cycles = 0;
	bit          hold_wanted = 1'b0;

	dxf_group_code_pair_tokenizer #(
		.MAX_VALUE_BUFFER(VALUE_BUF_MAX)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.value_limit_we(value_limit_we),
		.value_limit   (value_limit),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_tokenizer();
		tk_in_value = 1'b0;
		tk_brk      = BRK_NONE;
		tk_code     = '0;
		tk_neg      = 1'b0;
		tk_phase    = PH_BLANK;
		tk_comment  = 1'b0;
		tk_kept     = 0;
		tk_dropped  = 1'b0;
	endfunction

	// advance the tokenizer model by one byte; emits tells whether a result comes out
	function automatic void tokenize_byte(input in_beat_t b, output bit emits,
		output out_beat_t r);
		logic [7:0]        c;
		brk_t              prev;
		brk_t              next_brk;
		bit                is_digit;
		int unsigned       lim;
		logic [CODE_W-1:0] code;
		logic              comment;
		logic              trunc;
		c = b.data_byte;
		emits = 1'b0;
		r = '0;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

		// end of data wipes the parse whatever state it is in
		if (b.end_of_data || c == CH_NUL) begin
			clear_tokenizer();
			r.kind = KIND_EOD;
			emits = 1'b1;
			return;
		end

		// second half of a CR LF or LF CR pair is swallowed
		if (tk_brk != BRK_NONE) begin
			prev = tk_brk;
			tk_brk = BRK_NONE;
			if ((prev == BRK_CR && c == CH_LF) || (prev == BRK_LF && c == CH_CR))
				return;
		end

		// line break: close the code line or the value line
		if (c == CH_CR || c == CH_LF) begin
			next_brk = (c == CH_CR) ? BRK_CR : BRK_LF;
			if (!tk_in_value) begin
				if (tk_neg)
					tk_code = -tk_code;
				tk_neg      = 1'b0;
				tk_phase    = PH_BLANK;
				tk_comment  = (tk_code == COMMENT_CODE);
				tk_in_value = 1'b1;
				tk_kept     = 0;
				tk_dropped  = 1'b0;
			end else begin
				code    = tk_code;
				comment = tk_comment;
				trunc   = tk_dropped;
				clear_tokenizer();
				if (!comment) begin
					r.group_code = code;
					r.kind       = KIND_EOV;
					r.truncated  = trunc;
					emits        = 1'b1;
				end
			end
			tk_brk = next_brk;
			return;
		end

		// code line, read like atoi
		if (!tk_in_value) begin
			case (tk_phase)
				PH_BLANK: begin
					if (c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF) begin
						tk_phase = PH_BLANK;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						tk_neg   = (c == CH_MINUS);
						tk_phase = PH_SIGN;
					end else if (is_digit) begin
						tk_code  = 32'(c - CH_ZERO);
						tk_phase = PH_DIGIT;
					end else begin
						tk_phase = PH_DONE;
					end
				end
				PH_SIGN, PH_DIGIT: begin
					if (is_digit) begin
						tk_code  = tk_code * 32'd10 + 32'(c - CH_ZERO);
						tk_phase = PH_DIGIT;
					end else begin
						tk_phase = PH_DONE;
					end
				end
				default: ;
			endcase
			return;
		end

		if (tk_comment)
			return;

		// value character, kept while the buffer has room
		lim = limit_setting;
		if (lim > VALUE_BUF_MAX)
			lim = VALUE_BUF_MAX;
		if (lim < 1)
			lim = 1;
		if (tk_kept < lim - 1) begin
			tk_kept++;
			r.group_code = tk_code;
			r.value_char = c;
			r.kind       = KIND_CHAR;
			emits        = 1'b1;
		end else begin
			tk_dropped = 1'b1;
		end
	endfunction

	function automatic void feed_byte(input logic [7:0] b, input logic eod);
		feed_t f;
		f = '0;
		f.beat.data_byte   = b;
		f.beat.end_of_data = eod;
		byte_feed.push_back(f);
		fed_total++;
	endfunction

	// any byte except NUL, CR, LF and DEL, mostly printable
	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0:       c = 8'($urandom_range(128, 255));
			1:       c = 8'($urandom_range(1, 31));
			default: c = 8'($urandom_range(32, 126));
		endcase
		if (c == CH_CR || c == CH_LF)
			c = CH_SP;
		return c;
	endfunction

	function automatic void queue_break(input int unsigned shape);
		case (shape)
			0: feed_byte(CH_CR, 1'b0);
			1: feed_byte(CH_LF, 1'b0);
			2: begin
				feed_byte(CH_CR, 1'b0);
				feed_byte(CH_LF, 1'b0);
			end
			default: begin
				feed_byte(CH_LF, 1'b0);
				feed_byte(CH_CR, 1'b0);
			end
		endcase
	endfunction

	// one code/value pair with random content, sometimes preceded by noise
	function automatic void queue_pair(input int unsigned value_len);
		int unsigned shape;
		int unsigned brk;
		shape = $urandom_range(0, 19);
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) feed_byte(8'($urandom_range(0, 255)), 1'b0);
		if ($urandom_range(0, 24) == 0)
			feed_byte(8'($urandom_range(0, 255)), 1'b1);

		// code line: blanks, sign, digits, maybe trailing junk
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 3))
				0:       feed_byte(CH_SP, 1'b0);
				1:       feed_byte(CH_TAB, 1'b0);
				2:       feed_byte(CH_VT, 1'b0);
				default: feed_byte(CH_FF, 1'b0);
			endcase
		end
		if (shape > 1) begin
			case ($urandom_range(0, 3))
				0:       feed_byte(CH_PLUS, 1'b0);
				1:       feed_byte(CH_MINUS, 1'b0);
				default: ;
			endcase
		end
		if (shape <= 1) begin
			repeat (3) feed_byte(CH_NINE, 1'b0);
		end else if (shape <= 3) begin
			repeat ($urandom_range(10, 12))
				feed_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
		end else if (shape == 4) begin
			feed_byte(plain_byte(), 1'b0);
		end else begin
			repeat ($urandom_range(1, 4))
				feed_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
		end
		if ($urandom_range(0, 5) == 0)
			feed_byte(plain_byte(), 1'b0);

		// an empty value needs two identical single breaks to stay two lines
		if (value_len == 0) begin
			brk = $urandom_range(0, 1);
			queue_break(brk);
			queue_break(brk);
		end else begin
			queue_break($urandom_range(0, 3));
			repeat (value_len) feed_byte(plain_byte(), 1'b0);
			queue_break($urandom_range(0, 3));
		end
	endfunction

	task automatic settle_block();
		while (byte_feed.size() != 0 || in_valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [VALUE_LIMIT_W-1:0] v);
		@(posedge clk);
		value_limit_we <= 1'b1;
		value_limit    <= v;
		@(posedge clk);
		value_limit_we <= 1'b0;
		limit_setting = v;
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// sender: bursts of beats with random gaps in between
	always @(posedge clk) begin
		bit        emits;
		out_beat_t got;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// beat taken by the block: predict what it causes
			if (in_valid && !in_stall) begin
				tokenize_byte(cur_feed.beat, emits, got);
				if (cur_feed.typed)
					pending_results.push_back(cur_feed.want);
				else if (emits)
					pending_results.push_back(got);
			end
			// a stalled beat stays put, otherwise offer the next one
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (byte_feed.size() != 0) begin
					cur_feed = byte_feed.pop_front();
					in_data  <= cur_feed.beat;
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern that changes mode now and then, plus one long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_wanted) begin
			hold_wanted = 1'b0;
			hold_left   = 120;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(8, 64);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat expected none actual %0h", $time, out_data);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("group_code", want.group_code, out_data.group_code);
				check_field("value_char", 32'(want.value_char), 32'(out_data.value_char));
				check_field("kind", 32'(want.kind), 32'(out_data.kind));
				check_field("truncated", 32'(want.truncated), 32'(out_data.truncated));
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		logic [VALUE_LIMIT_W-1:0] lim;
		int unsigned              phase_start;
		int unsigned              len;
		clear_tokenizer();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// opening sequence at the reset buffer size
		foreach (OPENING[i])
			byte_feed.push_back(OPENING[i]);
		settle_block();

		// random pairs under several buffer sizes, extremes included
		for (int p = 0; p < 7; p++) begin
			case (p)
				0:       lim = 10'd1;
				1:       lim = 10'd2;
				2:       lim = 10'd0;
				3:       lim = 10'd3;
				4:       lim = 10'h3FF;
				5:       lim = 10'($urandom_range(4, 12));
				default: lim = 10'(LIMIT_RESET);
			endcase
			write_limit(lim);
			if (lim == 10'h3FF) begin
				// one value long enough to hit the clamped buffer size, with the
				// receiver holding off so the block backs up
				hold_wanted = 1'b1;
				feed_byte(8'h34, 1'b0);
				queue_break(1);
				repeat (LONG_VALUE) feed_byte(plain_byte(), 1'b0);
				queue_break(0);
			end
			phase_start = fed_total;
			while (fed_total - phase_start < PHASE_BYTES) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 5);
				queue_pair(len);
			end
			settle_block();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
